### rtl/mbwr_pkg.sv
// types, constants and crc helper for the write-register framer
`timescale 1ns / 1ps
`default_nettype none

package mbwr_pkg;

  // request kinds
  typedef enum logic [1:0] {
    CMD_ENABLE = 2'd0,
    CMD_MODE   = 2'd1,
    CMD_SPEED  = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE_ADDR = 2'd0,
    REG_MODE_ADDR   = 2'd1,
    REG_SPEED_ADDR  = 2'd2
  } reg_idx_t;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] ENABLE_ADDR_RESET = 16'd201;
  localparam logic [15:0] MODE_ADDR_RESET   = 16'd100;
  localparam logic [15:0] SPEED_ADDR_RESET  = 16'd401;
  localparam int          FRAME_LEN         = 8;
  localparam int          BYTE_IDX_W        = $clog2(FRAME_LEN);
  localparam int          CRC_BYTES         = 6;

  // one input item
  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         slave_id;
    logic signed [15:0] request_value;
  } req_t;

  // one result item
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_t;

  // crc-16 update over one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/modbus_write_register_framer_core.sv
// write-single-register frame builder with running crc-16
// the request is captured into the frame registers, and each frame byte leaves through the output register
// one frame byte per cycle while the receiver does not stall, set by the
// byte counter that walks the frame through the output register
// the next request is taken in the cycle the eighth byte is loaded
// reset: synchronous, restores the three register addresses and empties the output
`timescale 1ns / 1ps
`default_nettype none

module modbus_write_register_framer_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mbwr_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mbwr_pkg::frame_t   out_data,
  input  wire logic          cfg_write,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);

  localparam logic [mbwr_pkg::BYTE_IDX_W-1:0] LAST_IDX =
    mbwr_pkg::BYTE_IDX_W'(mbwr_pkg::FRAME_LEN - 1);
  localparam logic [mbwr_pkg::BYTE_IDX_W-1:0] CRC_LO_IDX =
    mbwr_pkg::BYTE_IDX_W'(mbwr_pkg::CRC_BYTES);

  logic [15:0] enable_addr;
  logic [15:0] mode_addr;
  logic [15:0] speed_addr;

  // frame being sent
  logic                             busy;
  logic [mbwr_pkg::BYTE_IDX_W-1:0]  idx;
  logic [7:0]                       slave_id;
  logic [15:0]                      reg_addr;
  logic [15:0]                      data_word;
  logic [15:0]                      crc;

  logic        advance;
  logic        take;
  logic        req_ok;
  logic [15:0] req_addr;
  logic [15:0] req_data;
  logic [7:0]  cur_byte;
  logic [7:0]  frame_bytes [mbwr_pkg::CRC_BYTES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_addr <= mbwr_pkg::ENABLE_ADDR_RESET;
      mode_addr   <= mbwr_pkg::MODE_ADDR_RESET;
      speed_addr  <= mbwr_pkg::SPEED_ADDR_RESET;
    end else if (cfg_write) begin
      case (mbwr_pkg::reg_idx_t'(cfg_index))
        mbwr_pkg::REG_ENABLE_ADDR: enable_addr <= cfg_data;
        mbwr_pkg::REG_MODE_ADDR:   mode_addr   <= cfg_data;
        mbwr_pkg::REG_SPEED_ADDR:  speed_addr  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode the request: address and data word per command
  always_comb begin
    req_ok   = 1'b1;
    req_addr = enable_addr;
    req_data = 16'h0000;
    case (mbwr_pkg::cmd_t'(in_data.command))
      mbwr_pkg::CMD_ENABLE: begin
        req_addr = enable_addr;
        req_data = {15'd0, in_data.request_value == 16'sd1};
      end
      mbwr_pkg::CMD_MODE: begin
        req_addr = mode_addr;
        req_data = {15'd0, in_data.request_value == 16'sd1};
      end
      mbwr_pkg::CMD_SPEED: begin
        req_addr = speed_addr;
        req_data = in_data.request_value;
      end
      default: req_ok = 1'b0;
    endcase
  end

  // handshake: output register moves when empty or taken
  assign advance  = busy && (!out_valid || !out_stall);
  assign in_stall = busy && !(advance && idx == LAST_IDX);
  assign take     = in_valid && !in_stall;

  // byte selection for the current position
  assign frame_bytes[0] = slave_id;
  assign frame_bytes[1] = mbwr_pkg::FUNC_WRITE_SINGLE;
  assign frame_bytes[2] = reg_addr[15:8];
  assign frame_bytes[3] = reg_addr[7:0];
  assign frame_bytes[4] = data_word[15:8];
  assign frame_bytes[5] = data_word[7:0];

  always_comb begin
    if (idx == LAST_IDX) begin
      cur_byte = crc[15:8];
    end else if (idx == CRC_LO_IDX) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = frame_bytes[idx[2:0] < 3'(mbwr_pkg::CRC_BYTES) ? idx : '0];
    end
  end

  // frame sequencer and running crc; a new request only lands when idle or on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take && req_ok) begin
      busy      <= 1'b1;
      idx       <= '0;
      crc       <= mbwr_pkg::CRC_INIT;
      slave_id  <= in_data.slave_id;
      reg_addr  <= req_addr;
      data_word <= req_data;
    end else if (advance) begin
      idx <= idx + 1'b1;
      if (idx < CRC_LO_IDX) begin
        crc <= mbwr_pkg::crc16_byte(crc, cur_byte);
      end
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid           <= 1'b1;
      out_data.frame_byte <= cur_byte;
      out_data.frame_last <= (idx == LAST_IDX);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// testbench for the write-register framer: directed table, random requests, frame checks
`timescale 1ns / 1ps

module testbench;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_ROWS      = 19;

  // one row of the directed table; head is the first six frame bytes when typed in
  typedef struct packed {
    mbwr_pkg::req_t req;
    logic           head_known;
    logic [47:0]    head;
  } dir_row_t;

  // heads assume the register addresses at reset: 0x00c9, 0x0064, 0x0191
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{'{mbwr_pkg::CMD_ENABLE, 8'h00, 16'sh0001}, 1'b1, 48'h00_06_00C9_0001},
    '{'{mbwr_pkg::CMD_ENABLE, 8'hFF, 16'sh0000}, 1'b1, 48'hFF_06_00C9_0000},
    '{'{mbwr_pkg::CMD_ENABLE, 8'h55, 16'shFFFF}, 1'b1, 48'h55_06_00C9_0000},
    '{'{mbwr_pkg::CMD_ENABLE, 8'h0F, 16'sh0002}, 1'b1, 48'h0F_06_00C9_0000},
    '{'{mbwr_pkg::CMD_MODE,   8'hAA, 16'sh0001}, 1'b1, 48'hAA_06_0064_0001},
    '{'{mbwr_pkg::CMD_MODE,   8'h01, 16'sh0101}, 1'b1, 48'h01_06_0064_0000},
    '{'{mbwr_pkg::CMD_MODE,   8'hF0, 16'sh8000}, 1'b1, 48'hF0_06_0064_0000},
    '{'{mbwr_pkg::CMD_MODE,   8'h80, 16'sh0001}, 1'b1, 48'h80_06_0064_0001},
    '{'{mbwr_pkg::CMD_SPEED,  8'h01, 16'sh7FFF}, 1'b1, 48'h01_06_0191_7FFF},
    '{'{mbwr_pkg::CMD_SPEED,  8'h02, 16'sh8000}, 1'b1, 48'h02_06_0191_8000},
    '{'{mbwr_pkg::CMD_SPEED,  8'h7F, 16'shFFFF}, 1'b1, 48'h7F_06_0191_FFFF},
    '{'{mbwr_pkg::CMD_SPEED,  8'h10, 16'sh0000}, 1'b1, 48'h10_06_0191_0000},
    '{'{mbwr_pkg::CMD_SPEED,  8'h11, 16'sh00FF}, 1'b1, 48'h11_06_0191_00FF},
    '{'{mbwr_pkg::CMD_SPEED,  8'h33, 16'sh1234}, 1'b1, 48'h33_06_0191_1234},
    '{'{CMD_UNUSED,           8'h12, 16'sh0001}, 1'b0, 48'h0},
    '{'{mbwr_pkg::CMD_SPEED,  8'h3C, 16'shFED4}, 1'b0, 48'h0},
    '{'{CMD_UNUSED,           8'hFF, 16'shFFFF}, 1'b0, 48'h0},
    '{'{mbwr_pkg::CMD_ENABLE, 8'hC3, 16'sh5A5A}, 1'b0, 48'h0},
    '{'{mbwr_pkg::CMD_SPEED,  8'hA5, 16'sh5A5A}, 1'b0, 48'h0}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  mbwr_pkg::req_t   in_data;
  logic             out_valid;
  logic             out_stall;
  mbwr_pkg::frame_t out_data;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;

  // head typed in for the item on offer, moves with in_data
  logic        cur_head_known;
  logic [47:0] cur_head;

  // mirror of the register addresses
  logic [15:0] enable_addr;
  logic [15:0] mode_addr;
  logic [15:0] speed_addr;

  mbwr_pkg::frame_t pending_bytes [$];
  int     errors = 0;
  int     quiet_cycles = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_req;

  modbus_write_register_framer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // build the expected frame for one request and queue its bytes
  function automatic void predict_frame(input mbwr_pkg::req_t r, input logic head_known,
                                        input logic [47:0] head);
    logic [15:0]      reg_addr;
    logic [15:0]      word;
    logic [15:0]      crc;
    logic [47:0]      body;
    logic             fb;
    mbwr_pkg::frame_t fr;
    reg_addr = '0;
    word     = '0;
    case (r.command)
      mbwr_pkg::CMD_ENABLE: begin
        reg_addr = enable_addr;
        word     = (r.request_value == 16'sd1) ? 16'd1 : 16'd0;
      end
      mbwr_pkg::CMD_MODE: begin
        reg_addr = mode_addr;
        word     = (r.request_value == 16'sd1) ? 16'd1 : 16'd0;
      end
      mbwr_pkg::CMD_SPEED: begin
        reg_addr = speed_addr;
        word     = r.request_value;
      end
      default: begin
        return;
      end
    endcase
    body = head_known ? head
                      : {r.slave_id, mbwr_pkg::FUNC_WRITE_SINGLE, reg_addr, word};
    // serial crc, each byte lsb first
    crc = mbwr_pkg::CRC_INIT;
    for (int k = 0; k < mbwr_pkg::CRC_BYTES; k++) begin
      for (int b = 0; b < 8; b++) begin
        fb  = crc[0] ^ body[40 - 8 * k + b];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ mbwr_pkg::CRC_POLY;
        end
      end
    end
    for (int k = 0; k < mbwr_pkg::FRAME_LEN; k++) begin
      if (k < mbwr_pkg::CRC_BYTES) begin
        fr.frame_byte = body[47 - 8 * k -: 8];
      end else if (k == mbwr_pkg::CRC_BYTES) begin
        fr.frame_byte = crc[7:0];
      end else begin
        fr.frame_byte = crc[15:8];
      end
      fr.frame_last = (k == mbwr_pkg::FRAME_LEN - 1);
      pending_bytes.push_back(fr);
    end
  endfunction

  function automatic mbwr_pkg::req_t random_req();
    mbwr_pkg::req_t r;
    int             pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      r.command = CMD_UNUSED;
    end else begin
      r.command = mbwr_pkg::cmd_t'($urandom_range(2));
    end
    r.slave_id = 8'($urandom);
    pick = $urandom_range(99);
    if (r.command == mbwr_pkg::CMD_SPEED) begin
      if (pick < 8) begin
        r.request_value = 16'sh7FFF;
      end else if (pick < 16) begin
        r.request_value = 16'sh8000;
      end else begin
        r.request_value = 16'($urandom);
      end
    end else begin
      r.request_value = (pick < 50) ? 16'sh0001 : 16'($urandom);
    end
    return r;
  endfunction

  // offer one item, idling first at random, return once it is taken
  task automatic send_req(input mbwr_pkg::req_t r, input logic head_known,
                          input logic [47:0] head);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data        <= r;
    cur_head_known <= head_known;
    cur_head       <= head;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // stop offering and wait until every queued byte has come out
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four indexes, top slot goes to the unused index
  task automatic load_addr_regs(input logic [3:0][15:0] vals);
    for (int i = 0; i <= REG_UNUSED; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (2'(i))
        mbwr_pkg::REG_ENABLE_ADDR: enable_addr = vals[i];
        mbwr_pkg::REG_MODE_ADDR:   mode_addr   = vals[i];
        mbwr_pkg::REG_SPEED_ADDR:  speed_addr  = vals[i];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_req(random_req(), 1'b0, 48'h0);
    end
    drain_frames();
  endtask

  // receiver stall, with one long hold-off when asked
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // predict on every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_frame(in_data, cur_head_known, cur_head);
    end
  end

  // compare every accepted frame byte with the oldest expectation
  always @(posedge clk) begin
    mbwr_pkg::frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %h last %b",
                             out_data.frame_byte, out_data.frame_last));
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.frame_byte !== want.frame_byte) begin
          flag_error($sformatf("frame_byte expected %h got %h",
                               want.frame_byte, out_data.frame_byte));
        end
        if (out_data.frame_last !== want.frame_last) begin
          flag_error($sformatf("frame_last expected %b got %b",
                               want.frame_last, out_data.frame_last));
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cur_head_known = 1'b0;
    cur_head       = '0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 10;
    recv_idle_pct  = 69;
    enable_addr    = mbwr_pkg::ENABLE_ADDR_RESET;
    mode_addr      = mbwr_pkg::MODE_ADDR_RESET;
    speed_addr     = mbwr_pkg::SPEED_ADDR_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset addresses
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_req(DIR_ROWS[i].req, DIR_ROWS[i].head_known, DIR_ROWS[i].head);
    end
    drain_frames();

    // all addresses zero, long receiver hold-off while requests keep coming
    load_addr_regs({16'($urandom), 16'h0000, 16'h0000, 16'h0000});
    hold_req = 1'b1;
    run_random(35);

    // all addresses at the top, idling swapped
    send_idle_pct = 69;
    recv_idle_pct = 10;
    load_addr_regs({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_random(35);

    load_addr_regs({16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
    run_random(30);

    // back to back, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_addr_regs({16'($urandom), 16'h8000, 16'h00FF, 16'h7FFF});
    run_random(35);

    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
